// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the hashed name table; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HNIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HNIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HNIT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HNIT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/hnit_pkg.sv =====
// ----------------------------------------------------------------------------
// hnit_pkg
// Shared constants, codes and types of the hashed name table.
// ----------------------------------------------------------------------------
package hnit_pkg;

    localparam int BUCKETS  = 64;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int CAPACITY = (BUCKETS / 4) * 3;
    localparam int ENT_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PRB_W    = BKT_W + 1;
    localparam int SLOT_W   = ENT_W + 1;
    localparam int ID_W     = 6;
    localparam int WORD_W   = 32;

    localparam logic [WORD_W-1:0] HASH_BASIS = 32'h811c9dc5;
    localparam logic [WORD_W-1:0] HASH_PRIME = 32'h01000193;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_BKT_RD,
        S_BKT_CHK,
        S_ENT_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] ns_id;
        logic [WORD_W-1:0] name_id;
        logic [WORD_W-1:0] type_size;
        logic [WORD_W-1:0] type_align;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   entry_id;
        t_status           status;
        logic [WORD_W-1:0] found_size;
        logic [WORD_W-1:0] found_align;
    } t_rsp;

    typedef struct packed {
        logic    load_in;
        logic    hash1;
        logic    hash2;
        logic    bkt_rd;
        logic    ent_rd;
        logic    step;
        logic    ins_wr;
        logic    res_set;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic full;
        logic bkt_empty;
        logic ent_match;
        logic probe_end;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/hnit_ifs.sv =====
// ----------------------------------------------------------------------------
// hnit_ifs
// Request and response channels of the hashed name table.
// ----------------------------------------------------------------------------
interface hnit_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] ns_id;
    logic [31:0] name_id;
    logic [31:0] type_size;
    logic [31:0] type_align;

    modport source (
        output valid, func, ns_id, name_id, type_size, type_align,
        input  ready
    );
    modport sink (
        input  valid, func, ns_id, name_id, type_size, type_align,
        output ready
    );
endinterface

interface hnit_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_id;
    logic [1:0]  status;
    logic [31:0] found_size;
    logic [31:0] found_align;

    modport source (
        output valid, entry_id, status, found_size, found_align,
        input  ready
    );
    modport sink (
        input  valid, entry_id, status, found_size, found_align,
        output ready
    );
endinterface

// ===== rtl/hnit_ctrl.sv =====
// ----------------------------------------------------------------------------
// hnit_ctrl
// Sequencer: hash, probe buckets, compare entries, insert, emit result.
// ----------------------------------------------------------------------------
module hnit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hnit_pkg::t_sts i_sts,
    output hnit_pkg::t_cmd o_cmd
);

    hnit_pkg::t_state r_state;
    hnit_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnit_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hnit_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = hnit_pkg::S_HASH1;
                end
            end
            hnit_pkg::S_HASH1: begin
                n_state = hnit_pkg::S_HASH2;
            end
            hnit_pkg::S_HASH2: begin
                if (i_sts.func == hnit_pkg::FUNC_INSERT && i_sts.full) begin
                    n_state = hnit_pkg::S_DONE;
                end else begin
                    n_state = hnit_pkg::S_BKT_RD;
                end
            end
            hnit_pkg::S_BKT_RD: begin
                if (i_sts.probe_end) begin
                    n_state = hnit_pkg::S_DONE;
                end else begin
                    n_state = hnit_pkg::S_BKT_CHK;
                end
            end
            hnit_pkg::S_BKT_CHK: begin
                if (i_sts.bkt_empty) begin
                    n_state = hnit_pkg::S_DONE;
                end else begin
                    n_state = hnit_pkg::S_ENT_CHK;
                end
            end
            hnit_pkg::S_ENT_CHK: begin
                if (i_sts.ent_match) begin
                    n_state = hnit_pkg::S_DONE;
                end else begin
                    n_state = hnit_pkg::S_BKT_RD;
                end
            end
            hnit_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = hnit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hnit_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            hnit_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            hnit_pkg::S_HASH1: begin
                o_cmd.hash1 = 1'b1;
            end
            hnit_pkg::S_HASH2: begin
                o_cmd.hash2 = 1'b1;
                if (i_sts.func == hnit_pkg::FUNC_INSERT && i_sts.full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = hnit_pkg::ST_FULL;
                end
            end
            hnit_pkg::S_BKT_RD: begin
                if (i_sts.probe_end) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = (i_sts.func == hnit_pkg::FUNC_INSERT) ?
                                     hnit_pkg::ST_FULL : hnit_pkg::ST_NOT_FOUND;
                end else begin
                    o_cmd.bkt_rd = 1'b1;
                end
            end
            hnit_pkg::S_BKT_CHK: begin
                if (i_sts.bkt_empty) begin
                    o_cmd.res_set = 1'b1;
                    if (i_sts.func == hnit_pkg::FUNC_INSERT) begin
                        o_cmd.ins_wr   = 1'b1;
                        o_cmd.res_code = hnit_pkg::ST_OK;
                    end else begin
                        o_cmd.res_code = hnit_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    o_cmd.ent_rd = 1'b1;
                end
            end
            hnit_pkg::S_ENT_CHK: begin
                if (i_sts.ent_match) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = (i_sts.func == hnit_pkg::FUNC_INSERT) ?
                                     hnit_pkg::ST_DUPLICATE : hnit_pkg::ST_OK;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            hnit_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/hnit_dp.sv =====
// ----------------------------------------------------------------------------
// hnit_dp
// Datapath: key hash, bucket and entry stores, probe pointer, result and
// output registers.
// ----------------------------------------------------------------------------
module hnit_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hnit_pkg::t_req i_req,
    input  hnit_pkg::t_cmd i_cmd,
    output hnit_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hnit_pkg::t_rsp o_rsp
);

    logic [hnit_pkg::SLOT_W-1:0] mem_bkt  [hnit_pkg::BUCKETS];
    logic [hnit_pkg::BUCKETS-1:0] r_bkt_vld;
    logic [hnit_pkg::WORD_W-1:0] mem_name  [hnit_pkg::CAPACITY];
    logic [hnit_pkg::WORD_W-1:0] mem_hash  [hnit_pkg::CAPACITY];
    logic [hnit_pkg::WORD_W-1:0] mem_size  [hnit_pkg::CAPACITY];
    logic [hnit_pkg::WORD_W-1:0] mem_align [hnit_pkg::CAPACITY];

    hnit_pkg::t_req              r_req;
    logic [hnit_pkg::WORD_W-1:0] r_h;
    logic [hnit_pkg::WORD_W-1:0] n_h;
    logic [hnit_pkg::BKT_W-1:0]  r_idx;
    logic [hnit_pkg::PRB_W-1:0]  r_nprobe;
    logic [hnit_pkg::CNT_W-1:0]  r_count;
    logic [hnit_pkg::SLOT_W-1:0] r_bkt_data;
    logic                        r_bkt_hit;
    logic [hnit_pkg::ENT_W-1:0]  r_slot;
    logic [hnit_pkg::WORD_W-1:0] r_ent_name;
    logic [hnit_pkg::WORD_W-1:0] r_ent_hash;
    logic [hnit_pkg::WORD_W-1:0] r_ent_size;
    logic [hnit_pkg::WORD_W-1:0] r_ent_align;
    hnit_pkg::t_rsp              r_res;
    hnit_pkg::t_rsp              r_out;
    logic                        r_out_vld;
    logic                        res_ok;

    assign n_h    = (r_h ^ r_req.name_id) * hnit_pkg::HASH_PRIME;
    assign res_ok = (i_cmd.res_code == hnit_pkg::ST_OK);

    // key registers and hash
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req;
        end
        if (i_cmd.hash1) begin
            r_h <= (hnit_pkg::HASH_BASIS ^ r_req.ns_id) * hnit_pkg::HASH_PRIME;
        end else if (i_cmd.hash2) begin
            r_h <= n_h;
        end
    end

    // probe pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash2) begin
            r_idx    <= n_h[hnit_pkg::BKT_W-1:0];
            r_nprobe <= '0;
        end else if (i_cmd.step) begin
            r_idx    <= r_idx + 1'b1;
            r_nprobe <= r_nprobe + 1'b1;
        end
    end

    // bucket store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            mem_bkt[r_idx] <= hnit_pkg::SLOT_W'(r_count);
        end
        if (i_cmd.bkt_rd) begin
            r_bkt_data <= mem_bkt[r_idx];
            r_bkt_hit  <= r_bkt_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bkt_vld <= '0;
            r_count   <= '0;
        end else if (i_cmd.ins_wr) begin
            r_bkt_vld[r_idx] <= 1'b1;
            r_count          <= r_count + 1'b1;
        end
    end

    // entry stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            mem_name[r_count[hnit_pkg::ENT_W-1:0]]  <= r_req.name_id;
            mem_hash[r_count[hnit_pkg::ENT_W-1:0]]  <= r_h;
            mem_size[r_count[hnit_pkg::ENT_W-1:0]]  <= r_req.type_size;
            mem_align[r_count[hnit_pkg::ENT_W-1:0]] <= r_req.type_align;
        end
        if (i_cmd.ent_rd) begin
            r_slot      <= r_bkt_data[hnit_pkg::ENT_W-1:0];
            r_ent_name  <= mem_name[r_bkt_data[hnit_pkg::ENT_W-1:0]];
            r_ent_hash  <= mem_hash[r_bkt_data[hnit_pkg::ENT_W-1:0]];
            r_ent_size  <= mem_size[r_bkt_data[hnit_pkg::ENT_W-1:0]];
            r_ent_align <= mem_align[r_bkt_data[hnit_pkg::ENT_W-1:0]];
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res.status <= i_cmd.res_code;
            if (!res_ok) begin
                r_res.entry_id <= '0;
            end else if (r_req.func == hnit_pkg::FUNC_INSERT) begin
                r_res.entry_id <= hnit_pkg::ID_W'(r_count);
            end else begin
                r_res.entry_id <= hnit_pkg::ID_W'(r_slot);
            end
            if (res_ok && r_req.func == hnit_pkg::FUNC_LOOKUP) begin
                r_res.found_size  <= r_ent_size;
                r_res.found_align <= r_ent_align;
            end else begin
                r_res.found_size  <= '0;
                r_res.found_align <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.func      = r_req.func;
    assign o_sts.full      = (r_count >= hnit_pkg::CNT_W'(hnit_pkg::CAPACITY));
    assign o_sts.bkt_empty = !r_bkt_hit ||
                             (r_bkt_data >= hnit_pkg::SLOT_W'(hnit_pkg::CAPACITY));
    assign o_sts.ent_match = (r_ent_hash == r_h) && (r_ent_name == r_req.name_id);
    assign o_sts.probe_end = (r_nprobe == hnit_pkg::PRB_W'(hnit_pkg::BUCKETS));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

// ===== rtl/hashed_name_to_id_table.sv =====
// ----------------------------------------------------------------------------
// hashed_name_to_id_table
// Hash table mapping a (namespace id, name id) key to a dense entry id.
// ----------------------------------------------------------------------------
// Requests arrive on i_req: func selects lookup or insert; the key is
// ns_id and name_id; type_size and type_align are stored on insert.
// Each request gives exactly one response on o_rsp with entry_id, status,
// found_size and found_align.
// One request is in work at a time. A request is captured, then hashed in
// two multiply steps, then the linear probe visits buckets (bucket read,
// check), with an entry compare for each occupied bucket, and the result
// is then loaded into the output register.
// An insert refused as full ends after hashing.
// i_req.ready is high only while the sequencer waits for a request.
// Synchronous reset empties the table (bucket valid bits clear at once, the
// id counter goes to zero) and drops any pending response; no clearing pass.
// A stalled receiver holds the response in the output register; the next
// request is still taken and processed, and waits before its result slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_name_to_id_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hnit_req_if.sink          i_req,
    hnit_rsp_if.source        o_rsp
);

    hnit_pkg::t_req req_pay;
    hnit_pkg::t_rsp rsp_pay;
    hnit_pkg::t_cmd cmd;
    hnit_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;

    assign req_pay.func       = i_req.func;
    assign req_pay.ns_id      = i_req.ns_id;
    assign req_pay.name_id    = i_req.name_id;
    assign req_pay.type_size  = i_req.type_size;
    assign req_pay.type_align = i_req.type_align;

    hnit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hnit_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_pay),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_rsp       (rsp_pay)
    );

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = out_valid;
    assign o_rsp.entry_id    = rsp_pay.entry_id;
    assign o_rsp.status      = rsp_pay.status;
    assign o_rsp.found_size  = rsp_pay.found_size;
    assign o_rsp.found_align = rsp_pay.found_align;

    `HNIT_ASSERT(a_req_busy, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready, "request taken while busy")
    `HNIT_ASSERT(a_id_range, i_clk, i_rst_n, o_rsp.valid |-> (o_rsp.entry_id < 6'(hnit_pkg::CAPACITY)), "entry id out of range")
    `HNIT_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_rsp.valid && (o_rsp.status != hnit_pkg::ST_OK)) |-> ((o_rsp.entry_id == '0) && (o_rsp.found_size == '0) && (o_rsp.found_align == '0)), "failed response not zeroed")
    `HNIT_ASSERT_ALWAYS(a_rst_idle, i_clk, (!i_rst_n) |=> (!o_rsp.valid && i_req.ready), "not idle after reset")

endmodule
